/* rtl/triangle_aspect_ratio_check_defines.svh */
// Assertion macros used by the RTL.
`ifndef TRIANGLE_ASPECT_RATIO_CHECK_DEFINES_SVH
`define TRIANGLE_ASPECT_RATIO_CHECK_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define TARC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define TARC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/tarc_pkg.sv */
`default_nettype none
package tarc_pkg;
    localparam int RATIO_BITS = 24;
    localparam logic [RATIO_BITS-1:0] LIMIT_RESET = 24'd5120;
    localparam logic [RATIO_BITS-1:0] RATIO_MAX = 24'hFFFFFF;
    localparam int OUT_BITS = 24;
    localparam int USER_BITS = 8;
endpackage
`default_nettype wire

/* rtl/triangle_aspect_ratio_check.sv */
// Pipeline: 5 geometry stages, 24 root/divide stages and 1 output register
//   between request accept and result valid.
// Throughput: one triangle per cycle; the whole pipe advances together and
//   holds while a finished result waits for m_axis_tready.
// Reset: rst_n asynchronous active low; clears all valid bits and loads the
//   limit register with 5120 (twenty in Q16.8). Payload registers are not reset.
`default_nettype none
`include "triangle_aspect_ratio_check_defines.svh"
module triangle_aspect_ratio_check #(
    parameter int COORD_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    // request: ax, ay, az, bx, by, bz, cx, cy, cz (lowest first), zero padded
    input  wire logic [((9*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // result: ratio (Q16.8)
    output logic [tarc_pkg::OUT_BITS-1:0] m_axis_tdata,
    // result flags: bit 0 over_limit, bit 1 degenerate
    output logic [tarc_pkg::USER_BITS-1:0] m_axis_tuser,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    input  wire logic cfg_we,
    input  wire logic [tarc_pkg::RATIO_BITS-1:0] cfg_wdata
);
    // Widths all follow from the coordinate width C:
    //   edge deltas need C+1 signed bits; squared edge lengths sum below 2^(2C+2);
    //   cross components fit 2C+3 signed bits; A2 fits 4C+6 bits.
    localparam int C   = COORD_BITS;
    localparam int D   = C + 1;
    localparam int PRW = 2 * D;
    localparam int SQW = 2 * C;
    localparam int L2W = 2 * C + 2;
    localparam int CRW = 2 * C + 3;
    localparam int CMW = CRW - 1;
    localparam int CSW = 2 * CMW;
    localparam int A2W = 4 * C + 6;
    localparam int LSW = 2 * L2W;
    localparam int RB  = tarc_pkg::RATIO_BITS;
    // remainder holds 65536 * L2^2 - r^2 * A2
    localparam int RW  = LSW + 16;
    // P holds r * A2
    localparam int PW  = A2W + RB;
    localparam int TW  = PW + RB + 1;

    // Whole pipe moves when the output register is free or being drained.
    logic adv;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    logic [RB-1:0] limit_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= tarc_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    // ---------------- stage 1: edge vectors ----------------
    logic signed [C-1:0] crd [0:8];
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            crd[i] = s_axis_tdata[i*C +: C];
        end
    end

    logic signed [D-1:0] e_reg [0:8];   // u xyz, v xyz, w xyz
    logic                v1_reg;
    logic signed [D-1:0] e_next [0:8];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            // u = a - b, v = b - c, w = c - a
            e_next[i]   = {crd[i][C-1], crd[i]}     - {crd[i+3][C-1], crd[i+3]};
            e_next[i+3] = {crd[i+3][C-1], crd[i+3]} - {crd[i+6][C-1], crd[i+6]};
            e_next[i+6] = {crd[i+6][C-1], crd[i+6]} - {crd[i][C-1], crd[i]};
        end
    end

    // ---------------- stage 2: squares and cross terms ----------------
    logic [SQW-1:0]        sq_reg [0:8];
    logic signed [PRW-1:0] xp_reg [0:5];
    logic                  v2_reg;
    logic signed [PRW-1:0] sq_full [0:8];
    logic signed [PRW-1:0] xp_next [0:5];
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            sq_full[i] = e_reg[i] * e_reg[i];
        end
        // u = e[0..2], w = e[6..8]
        xp_next[0] = e_reg[1] * e_reg[8];   // uy*wz
        xp_next[1] = e_reg[2] * e_reg[7];   // uz*wy
        xp_next[2] = e_reg[2] * e_reg[6];   // uz*wx
        xp_next[3] = e_reg[0] * e_reg[8];   // ux*wz
        xp_next[4] = e_reg[0] * e_reg[7];   // ux*wy
        xp_next[5] = e_reg[1] * e_reg[6];   // uy*wx
    end

    // ---------------- stage 3: L2 and cross product ----------------
    logic [L2W-1:0]        l2_reg;
    logic signed [CRW-1:0] cr_reg [0:2];
    logic                  v3_reg;
    logic [L2W-1:0]        len [0:2];
    logic [L2W-1:0]        l2_next;
    logic signed [CRW-1:0] cr_next [0:2];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            len[i] = L2W'(sq_reg[3*i]) + L2W'(sq_reg[3*i+1]) + L2W'(sq_reg[3*i+2]);
            cr_next[i] = {xp_reg[2*i][PRW-1], xp_reg[2*i]}
                       - {xp_reg[2*i+1][PRW-1], xp_reg[2*i+1]};
        end
        l2_next = len[0];
        if (len[1] > l2_next)
        begin
            l2_next = len[1];
        end
        if (len[2] > l2_next)
        begin
            l2_next = len[2];
        end
    end

    // ---------------- stage 4: squared cross components ----------------
    logic [CSW-1:0] cs_reg [0:2];
    logic [L2W-1:0] l2b_reg;
    logic           v4_reg;
    logic [CMW-1:0] cmag [0:2];
    logic [CRW-1:0] cneg [0:2];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cneg[i] = -cr_reg[i];
            cmag[i] = cr_reg[i][CRW-1] ? cneg[i][CMW-1:0] : cr_reg[i][CMW-1:0];
        end
    end

    // ---------------- stage 5: A2 and L2^2 ----------------
    logic [A2W-1:0] a2_next;
    logic [LSW-1:0] l2sq_next;
    assign a2_next = A2W'(cs_reg[0]) + A2W'(cs_reg[1]) + A2W'(cs_reg[2]);
    assign l2sq_next = l2b_reg * l2b_reg;

    // ---------------- stages 6..29: restoring root/divide ----------------
    // Bit B of r is set when (r + 2^B)^2 * A2 still fits under 65536 * L2^2.
    // With P = r*A2 the increase is (P << (B+1)) + (A2 << 2B): shifts and adds only.
    logic [RW-1:0]  rem_reg  [0:RB];
    logic [PW-1:0]  p_reg    [0:RB];
    logic [A2W-1:0] a2_reg   [0:RB];
    logic [RB-1:0]  r_reg    [0:RB];
    logic [RB:0]    deg_reg;
    logic [RB:0]    iv_reg;
    logic [RW-1:0]  rem_next [1:RB];
    logic [PW-1:0]  p_next   [1:RB];
    logic [RB-1:0]  r_next   [1:RB];

    for (genvar k = 0; k < RB; k++)
    begin : g_iter
        localparam int B = RB - 1 - k;
        logic [TW-1:0] term;
        logic          fits;
        always_comb
        begin
            term = (TW'(p_reg[k]) << (B + 1)) + (TW'(a2_reg[k]) << (2 * B));
            fits = term <= TW'(rem_reg[k]);
            rem_next[k+1] = fits ? rem_reg[k] - term[RW-1:0] : rem_reg[k];
            p_next[k+1]   = fits ? p_reg[k] + (PW'(a2_reg[k]) << B) : p_reg[k];
            r_next[k+1]   = fits ? (r_reg[k] | (RB'(1) << B)) : r_reg[k];
        end
    end

    // ---------------- output register ----------------
    logic [RB-1:0] ratio_reg;
    logic          over_reg;
    logic          degen_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            iv_reg        <= '0;
            m_axis_tvalid <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= s_axis_tvalid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            iv_reg        <= {iv_reg[RB-1:0], v4_reg};
            m_axis_tvalid <= iv_reg[RB];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_reg  <= e_next;
            for (int i = 0; i < 9; i++)
            begin
                sq_reg[i] <= sq_full[i][SQW-1:0];
            end
            xp_reg <= xp_next;
            l2_reg <= l2_next;
            cr_reg <= cr_next;
            l2b_reg <= l2_reg;
            for (int i = 0; i < 3; i++)
            begin
                cs_reg[i] <= cmag[i] * cmag[i];
            end
            rem_reg[0] <= {l2sq_next, 16'd0};
            p_reg[0]   <= '0;
            r_reg[0]   <= '0;
            a2_reg[0]  <= a2_next;
            deg_reg[0] <= (a2_next == '0);
            for (int k = 1; k <= RB; k++)
            begin
                rem_reg[k] <= rem_next[k];
                p_reg[k]   <= p_next[k];
                r_reg[k]   <= r_next[k];
                a2_reg[k]  <= a2_reg[k-1];
                deg_reg[k] <= deg_reg[k-1];
            end
            ratio_reg <= r_reg[RB];
            over_reg  <= r_reg[RB] > limit_reg;
            degen_reg <= deg_reg[RB];
        end
    end

    assign m_axis_tdata = ratio_reg;
    assign m_axis_tuser = {(tarc_pkg::USER_BITS - 2)'(0), degen_reg, over_reg};

    // Degenerate triangles always come out saturated.
    `TARC_ASSERT_NOW(a_degen_sat, clk, rst_n, m_axis_tvalid && degen_reg,
        ratio_reg == tarc_pkg::RATIO_MAX)
    // Flag matches limit_reg; user must change config only when idle, unenforced.
    `TARC_ASSERT_NOW(a_over_flag, clk, rst_n, m_axis_tvalid && !cfg_we,
        over_reg == (ratio_reg > limit_reg))
    // A stalled pipe accepts nothing.
    `TARC_ASSERT_NOW(a_stall_ready, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        !s_axis_tready)
    // An item leaving the last root stage shows up at the output next cycle.
    `TARC_ASSERT_NEXT(a_out_follow, clk, rst_n, adv && iv_reg[RB], m_axis_tvalid)
endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none
// Triangle aspect-ratio checker testbench.
// A queue of triangles feeds a bursty driver; a monitor checks each result
// against an exact predictor (longest squared edge over the root of the
// squared cross-product norm, Q16.8, saturated) computed on wide integers.
module tb_top;
    localparam int COORD_BITS = 16;
    localparam int DATA_BITS = ((9*COORD_BITS+7)/8)*8;
    localparam int LATENCY = 30;
    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD = 200;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct {
        logic [tarc_pkg::RATIO_BITS-1:0] ratio;
        logic over_limit;
        logic degenerate;
    } quality_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic [DATA_BITS-1:0] s_axis_tdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [tarc_pkg::OUT_BITS-1:0] m_axis_tdata;
    logic [tarc_pkg::USER_BITS-1:0] m_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic cfg_we = 1'b0;
    logic [tarc_pkg::RATIO_BITS-1:0] cfg_wdata = '0;

    triangle_aspect_ratio_check #(.COORD_BITS(COORD_BITS)) u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor copy of the limit register.
    logic [tarc_pkg::RATIO_BITS-1:0] limit_q = tarc_pkg::LIMIT_RESET;

    logic [DATA_BITS-1:0] pending_tris[$];
    quality_t expected_quality[$];
    int errors = 0;
    int n_results = 0;
    int n_degenerate = 0;
    int n_over = 0;
    int n_saturated = 0;
    bit hold_long = 1'b0;
    int idle_cycles = 0;

    // Exact aspect ratio: largest r with r*r*A2 <= 65536*L2*L2.
    function automatic quality_t predict_quality(logic [DATA_BITS-1:0] tri_bits);
        longint v[9];
        longint ux, uy, uz, wx, wy, wz, vx, vy, vz, px, py, pz;
        logic [191:0] l2, t, a2, rhs, cand, lhs;
        logic [tarc_pkg::RATIO_BITS-1:0] r;
        quality_t q;
        for (int i = 0; i < 9; i++)
            v[i] = longint'(coord_t'(tri_bits[i*COORD_BITS +: COORD_BITS]));
        ux = v[0] - v[3]; uy = v[1] - v[4]; uz = v[2] - v[5];
        vx = v[3] - v[6]; vy = v[4] - v[7]; vz = v[5] - v[8];
        wx = v[6] - v[0]; wy = v[7] - v[1]; wz = v[8] - v[2];
        l2 = 192'(ux*ux + uy*uy + uz*uz);
        t = 192'(vx*vx + vy*vy + vz*vz);
        if (t > l2) l2 = t;
        t = 192'(wx*wx + wy*wy + wz*wz);
        if (t > l2) l2 = t;
        px = uy*wz - uz*wy;
        py = uz*wx - ux*wz;
        pz = ux*wy - uy*wx;
        // each product fits 64 bits signed; square as 192-bit magnitudes
        a2 = 192'(px < 0 ? -px : px) * 192'(px < 0 ? -px : px)
           + 192'(py < 0 ? -py : py) * 192'(py < 0 ? -py : py)
           + 192'(pz < 0 ? -pz : pz) * 192'(pz < 0 ? -pz : pz);
        rhs = (l2 * l2) << 16;
        r = '0;
        for (int b = tarc_pkg::RATIO_BITS - 1; b >= 0; b--)
        begin
            cand = 192'(r | (24'd1 << b));
            lhs = cand * cand * a2;
            if (lhs <= rhs) r = cand[tarc_pkg::RATIO_BITS-1:0];
        end
        q.ratio = r;
        q.over_limit = (r > limit_q);
        q.degenerate = (a2 == 0);
        return q;
    endfunction

    function automatic logic [DATA_BITS-1:0] pack_tri(coord_t c[9]);
        logic [DATA_BITS-1:0] d;
        d = '0;
        for (int i = 0; i < 9; i++)
            d[i*COORD_BITS +: COORD_BITS] = c[i];
        return d;
    endfunction

    // Random coordinate: full range, corners, or small values near a base.
    function automatic coord_t rand_coord(int mode, coord_t base);
        case (mode)
            0: return coord_t'($urandom);
            1: return ($urandom_range(0, 1) != 0) ? coord_t'(16'h7FFF) : coord_t'(16'h8000);
            default: return coord_t'(base + $signed($urandom_range(0, 16)) - 8);
        endcase
    endfunction

    // Mostly non-degenerate shapes; some slivers, collinear and repeated points.
    function automatic logic [DATA_BITS-1:0] rand_tri();
        coord_t c[9];
        int kind;
        int k;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++)
            c[i] = rand_coord(kind == 0 ? 1 : (kind < 5 ? 0 : 2), coord_t'($urandom));
        if (kind >= 5)
        begin
            for (int i = 3; i < 9; i++)
                c[i] = rand_coord(2, c[i % 3]);
        end
        if (kind == 8)
        begin
            // collinear: c = a + k*(b - a) within small range
            k = $urandom_range(1, 3);
            for (int i = 0; i < 3; i++)
                c[6+i] = coord_t'(c[i] + k*(c[3+i] - c[i]));
        end
        if (kind == 9)
            for (int i = 0; i < 3; i++)
                c[3+i] = c[i];
        return pack_tri(c);
    endfunction

    task automatic push_tri(int a0, int a1, int a2, int b0, int b1,
                            int b2, int c0, int c1, int c2);
        coord_t c[9];
        c = '{coord_t'(a0), coord_t'(a1), coord_t'(a2), coord_t'(b0), coord_t'(b1),
              coord_t'(b2), coord_t'(c0), coord_t'(c1), coord_t'(c2)};
        pending_tris.insert(pending_tris.size(), pack_tri(c));
    endtask

    // Limit register write; only called while the pipe is empty.
    task automatic write_limit(logic [tarc_pkg::RATIO_BITS-1:0] val);
        while (pending_tris.size() != 0 || expected_quality.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        limit_q = val;
    endtask

    // Driver: bursts of random length, random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_quality.insert(expected_quality.size(),
                                        predict_quality(s_axis_tdata));
                void'(pending_tris.pop_front());
            end
            if (s_axis_tvalid && !s_axis_tready)
                ; // hold the request until taken
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_tris.size() != 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_tris[0];
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver stall pattern, plus a long hold-off on request.
    int ready_phase = 0;
    int hold_count = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            ready_phase <= ready_phase + 1;
            if (hold_long && hold_count < LONG_HOLD)
            begin
                hold_count <= hold_count + 1;
                m_axis_tready <= 1'b0;
            end
            else if (ready_phase[9])
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= (ready_phase % 7 < 4) || ($urandom_range(0, 3) == 0);
        end
    end

    // Monitor: compare each result with the oldest prediction.
    always @(posedge clk)
    begin
        quality_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results <= n_results + 1;
            if (expected_quality.size() == 0)
            begin
                $display("%0t: unexpected result ratio=%h user=%h", $time,
                         m_axis_tdata, m_axis_tuser);
                errors++;
            end
            else
            begin
                e = expected_quality.pop_front();
                if (e.degenerate) n_degenerate <= n_degenerate + 1;
                if (e.over_limit) n_over <= n_over + 1;
                if (e.ratio == tarc_pkg::RATIO_MAX) n_saturated <= n_saturated + 1;
                if (m_axis_tdata != e.ratio)
                begin
                    $display("%0t: ratio expected %h actual %h", $time, e.ratio,
                             m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser != {(tarc_pkg::USER_BITS - 2)'(0), e.degenerate,
                                     e.over_limit})
                begin
                    $display("%0t: flags expected %b%b actual %h", $time, e.degenerate,
                             e.over_limit, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted request or result.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results pending", $time,
                     expected_quality.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: right triangle, extremes, degenerate cases, sliver.
        push_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);
        push_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
        push_tri(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        push_tri(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        push_tri(-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, -32768);
        push_tri(32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767);
        push_tri(0, 0, 0, 10, 10, 10, 20, 20, 20);
        push_tri(0, 0, 0, 5, 0, 0, 5, 0, 0);
        push_tri(-32768, 0, 0, 32767, 0, 0, 0, 1, 0);
        push_tri(-32768, -32768, 0, 32767, 32767, 0, 32767, 32766, 0);
        push_tri(-32768, 0, 0, 32767, 0, 0, 0, 0, 1);
        push_tri(0, 0, 0, 20, 0, 0, 0, 1, 0);
        push_tri(0, 0, 0, 40, 0, 0, 20, 1, 0);
        push_tri(1, 2, 3, -4, 5, -6, 7, -8, 9);
        push_tri(-1, -1, -1, 1, 1, 1, -1, 1, -1);
        push_tri(32767, 0, 0, 0, 32767, 0, 0, 0, 32767);

        write_limit(24'd0);
        for (int i = 0; i < 60; i++) pending_tris.insert(pending_tris.size(), rand_tri());
        write_limit(tarc_pkg::RATIO_MAX);
        push_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
        push_tri(0, 0, 0, 3, 0, 0, 6, 0, 0);
        for (int i = 0; i < 60; i++) pending_tris.insert(pending_tris.size(), rand_tri());
        write_limit(24'd512);
        // long receiver hold-off while the driver keeps offering
        hold_long = 1'b1;
        for (int i = 0; i < 140; i++) pending_tris.insert(pending_tris.size(), rand_tri());
        write_limit(24'h00FFFF & 24'($urandom));
        for (int i = 0; i < 140; i++) pending_tris.insert(pending_tris.size(), rand_tri());

        while (pending_tris.size() != 0 || expected_quality.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("Checked %0d triangles over 5 limit settings: %0d degenerate,",
                 n_results, n_degenerate);
        $display("%0d saturated, %0d over limit.", n_saturated, n_over);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
